### rtl/core/dfr_pkg.sv
// Shared types and constants of the delimited frame receiver.
package dfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int NUM_SLOTS = 6;
  localparam int POS_W     = 4;
  localparam int DATA_W    = NUM_SLOTS * BYTE_W;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Position at which a frame that is still open overflows (8 to 15).
  localparam logic [POS_W-1:0] FRAME_LIMIT = 4'd10;

  localparam logic [BYTE_W-1:0] START_RESET = 8'hFD;
  localparam logic [BYTE_W-1:0] END_RESET   = 8'hFE;

  // Register index is paddr[2].
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam logic STATUS_ERROR = 1'b0;
  localparam logic STATUS_OK    = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } codes_t;

endpackage

### rtl/core/dfr_apb_regs.sv
// APB register file holding the start and end codes.
module dfr_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfr_pkg::APB_AW-1:0] paddr,
  input  logic [dfr_pkg::APB_DW-1:0] pwdata,
  output logic [dfr_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output dfr_pkg::codes_t            codes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code <= dfr_pkg::START_RESET;
      codes.end_code   <= dfr_pkg::END_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        dfr_pkg::REG_START: codes.start_code <= pwdata[dfr_pkg::BYTE_W-1:0];
        dfr_pkg::REG_END:   codes.end_code   <= pwdata[dfr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      dfr_pkg::REG_START: prdata[dfr_pkg::BYTE_W-1:0] = codes.start_code;
      dfr_pkg::REG_END:   prdata[dfr_pkg::BYTE_W-1:0] = codes.end_code;
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/core/delimited_frame_receiver_top.sv
// Top level of the delimited frame receiver: frame parser and result register.
//
//  channel  direction  transaction payload
//  s_*      in         s_tdata = rx_byte
//  m_*      out        m_tuser = frame_status, m_tdata = six frame bytes
//  APB      in         start_code at 0x0, end_code at 0x4
//
// One byte per cycle while s_tready is high; a result appears in the output register
// the cycle after its byte is accepted. Frame state and slots update in the accept cycle.
// s_tready is high while the output register is empty or being drained,
// so a stall on m_* holds off s_* only while a result waits.
// Reset clears frame state and slots and loads the default codes; no clear pass.
module delimited_frame_receiver_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dfr_pkg::DATA_W-1:0] m_tdata,   // header, type_high, type_low,
                                                // group_class, first_command,
                                                // second_command (low byte up)
  output logic                       m_tuser,   // [0] frame_status
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfr_pkg::APB_AW-1:0] paddr,
  input  logic [dfr_pkg::APB_DW-1:0] pwdata,
  output logic [dfr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  dfr_pkg::codes_t codes;

  logic                         in_frame, in_frame_next;
  logic [dfr_pkg::POS_W-1:0]    pos, pos_next, pos_inc;
  logic [dfr_pkg::BYTE_W-1:0]   slots      [dfr_pkg::NUM_SLOTS];
  logic [dfr_pkg::BYTE_W-1:0]   slots_view [dfr_pkg::NUM_SLOTS];
  logic                         s_accept, is_start, is_end;
  logic                         load, load_status, clear_slots;
  logic [dfr_pkg::DATA_W-1:0]   load_data;

  dfr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes   (codes)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign is_start = (s_tdata == codes.start_code);
  assign is_end   = (s_tdata == codes.end_code);
  assign pos_inc  = pos + 4'd1;

  // Slot contents including the byte stored this cycle.
  always_comb begin
    for (int j = 0; j < dfr_pkg::NUM_SLOTS; j++) begin
      slots_view[j] = slots[j];
      if (s_accept && in_frame && (pos_inc == dfr_pkg::POS_W'(j + 1)))
        slots_view[j] = s_tdata;
    end
  end

  always_comb begin
    in_frame_next = in_frame;
    pos_next      = pos;
    load          = 1'b0;
    load_status   = dfr_pkg::STATUS_ERROR;
    clear_slots   = 1'b0;
    load_data     = '0;
    if (s_accept) begin
      if (!in_frame) begin
        if (is_start) begin
          in_frame_next = 1'b1;
          pos_next      = '0;
        end else begin
          load = 1'b1;
        end
      end else begin
        pos_next = pos_inc;
        if (is_start) begin
          pos_next = '0;
        end else if (is_end) begin
          in_frame_next = 1'b0;
          load          = 1'b1;
          load_status   = dfr_pkg::STATUS_OK;
          clear_slots   = 1'b1;
          for (int j = 0; j < dfr_pkg::NUM_SLOTS; j++)
            load_data[j*dfr_pkg::BYTE_W +: dfr_pkg::BYTE_W] = slots_view[j];
        end else if (pos_inc >= dfr_pkg::FRAME_LIMIT) begin
          in_frame_next = 1'b0;
          load          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
      m_tvalid <= 1'b0;
      for (int j = 0; j < dfr_pkg::NUM_SLOTS; j++)
        slots[j] <= '0;
    end else begin
      in_frame <= in_frame_next;
      pos      <= pos_next;
      for (int j = 0; j < dfr_pkg::NUM_SLOTS; j++)
        slots[j] <= clear_slots ? '0 : slots_view[j];
      if (load)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= load_data;
      m_tuser <= load_status;
    end
  end

`ifndef SYNTHESIS
  a_slots_cleared: assert property (@(posedge clk) disable iff (rst)
    (load && load_status == dfr_pkg::STATUS_OK) |=>
      (slots[0] == '0 && slots[1] == '0 && slots[2] == '0 &&
       slots[3] == '0 && slots[4] == '0 && slots[5] == '0))
    else $error("slots not cleared after a good frame");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (pos < dfr_pkg::FRAME_LIMIT))
    else $error("open frame at or past the limit");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dfr_pkg::STATUS_ERROR) |-> (m_tdata == '0))
    else $error("error result carries data");

  a_idle_error: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !in_frame && !is_start) |=>
      (m_tvalid && m_tuser == dfr_pkg::STATUS_ERROR))
    else $error("stray byte while idle gave no error");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for the delimited frame receiver: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
  import dfr_pkg::*;

  typedef struct packed {
    logic                             status;
    logic [NUM_SLOTS-1:0][BYTE_W-1:0] field;   // [0] = header
  } frame_result_t;

  // How a directed row is checked: by the predictor, as a typed-in error, or not at all.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ERROR} row_check_t;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    row_check_t        chk;
  } stim_row_t;

  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 260;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  delimited_frame_receiver_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Frame parser state as the bench sees it
  logic [BYTE_W-1:0]                start_code_q = START_RESET;
  logic [BYTE_W-1:0]                end_code_q   = END_RESET;
  logic                             frame_open   = 1'b0;
  logic [POS_W-1:0]                 frame_pos    = '0;
  logic [NUM_SLOTS-1:0][BYTE_W-1:0] frame_slots  = '0;

  frame_result_t pending_frames[$];
  int            fail_count   = 0;
  int            bytes_sent   = 0;
  int            tx_idle_pct  = 7;
  int            rx_stall_pct = 63;

  string field_names [NUM_SLOTS] = '{"header", "type_high", "type_low",
                                     "group_class", "first_command", "second_command"};

  stim_row_t directed_rows [27] = '{
    '{8'h00, CHK_ERROR},  // junk while idle
    '{8'hFD, CHK_NONE},   // open
    '{8'hFF, CHK_MODEL},
    '{8'h00, CHK_MODEL},
    '{8'h80, CHK_MODEL},
    '{8'h7F, CHK_MODEL},
    '{8'h01, CHK_MODEL},
    '{8'h02, CHK_MODEL},
    '{8'h03, CHK_MODEL},  // past the slots, dropped
    '{8'h04, CHK_MODEL},
    '{8'h05, CHK_MODEL},
    '{8'h5A, CHK_ERROR},  // overflow at the limit
    '{8'hFD, CHK_NONE},
    '{8'hFD, CHK_NONE},   // restart, code lands in header slot
    '{8'hFE, CHK_MODEL},  // short frame shows slots left over from the overflow
    '{8'hFD, CHK_NONE},
    '{8'hA5, CHK_MODEL},
    '{8'h5A, CHK_MODEL},
    '{8'hC3, CHK_MODEL},
    '{8'h3C, CHK_MODEL},
    '{8'h96, CHK_MODEL},
    '{8'h69, CHK_MODEL},
    '{8'hF0, CHK_MODEL},
    '{8'h0F, CHK_MODEL},
    '{8'hAA, CHK_MODEL},
    '{8'hFE, CHK_MODEL},  // end code right at the limit still succeeds
    '{8'hFE, CHK_ERROR}   // end code while idle
  };

  // Advances the parser by one byte; returns 1 when the byte produces a result.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output frame_result_t res);
    res = '0;
    if (!frame_open) begin
      if (b == start_code_q) begin
        frame_open = 1'b1;
        frame_pos  = '0;
        return 1'b0;
      end
      res.status = STATUS_ERROR;
      return 1'b1;
    end
    frame_pos = frame_pos + 1'b1;
    if (frame_pos >= 1 && frame_pos <= NUM_SLOTS)
      frame_slots[frame_pos - 1] = b;
    if (b == start_code_q) begin
      frame_pos = '0;
      return 1'b0;
    end
    if (b == end_code_q) begin
      frame_open  = 1'b0;
      res.status  = STATUS_OK;
      res.field   = frame_slots;
      frame_slots = '0;
      return 1'b1;
    end
    if (frame_pos >= FRAME_LIMIT) begin
      frame_open = 1'b0;
      res.status = STATUS_ERROR;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_check_t chk);
    frame_result_t res;
    bit            has_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    has_res = parse_byte(b, res);
    case (chk)
      CHK_MODEL: if (has_res) pending_frames.push_back(res);
      CHK_ERROR: begin
        res        = '0;
        res.status = STATUS_ERROR;
        pending_frames.push_back(res);
      end
      default: ;
    endcase
    bytes_sent++;
    @(negedge clk);
  endtask

  // Writes a code register, then reads it back.
  task automatic write_code(input logic reg_sel, input logic [BYTE_W-1:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {{(APB_DW-BYTE_W){1'b0}}, code};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_START) start_code_q = code;
    else end_code_q = code;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[BYTE_W-1:0] !== code) begin
      $error("prdata: expected %h, got %h", code, prdata[BYTE_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly avoids the codes so frames run long; now and then lets one through.
  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] b;
    bit                avoid;
    avoid = ($urandom_range(19) != 0);
    do b = 8'($urandom_range(255));
    while (avoid && (b == start_code_q || b == end_code_q));
    return b;
  endfunction

  task automatic send_random_unit();
    int shape;
    int len;
    shape = $urandom_range(99);
    if (shape < 20) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), CHK_MODEL);
    end else begin
      shape = $urandom_range(99);
      if (shape < 65) len = $urandom_range(NUM_SLOTS, 0);
      else if (shape < 85) len = $urandom_range(int'(FRAME_LIMIT) - 1, NUM_SLOTS + 1);
      else len = $urandom_range(int'(FRAME_LIMIT) + 2, int'(FRAME_LIMIT));
      send_byte(start_code_q, CHK_MODEL);
      for (int n = 0; n < len; n++) send_byte(payload_byte(), CHK_MODEL);
      if (len < FRAME_LIMIT) send_byte(end_code_q, CHK_MODEL);
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result with none pending: status %b data %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (m_tuser !== want.status) begin
          $error("frame_status: expected %b, got %b", want.status, m_tuser);
          fail_count++;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (m_tdata[BYTE_W*k +: BYTE_W] !== want.field[k]) begin
            $error("%s: expected %h, got %h", field_names[k], want.field[k],
                   m_tdata[BYTE_W*k +: BYTE_W]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] new_start;
    logic [BYTE_W-1:0] new_end;
    int                quota;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_byte(directed_rows[i].rx, directed_rows[i].chk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: begin new_start = START_RESET; new_end = END_RESET; end
        1: begin new_start = 8'h00; new_end = 8'hFF; end
        2: begin new_start = 8'hFF; new_end = 8'h00; end
        3: begin new_start = 8'h55; new_end = 8'h55; end  // equal codes: overflow only
        default: begin
          new_start = 8'($urandom_range(255));
          new_end   = 8'($urandom_range(255));
        end
      endcase
      write_code(REG_START, new_start);
      write_code(REG_END, new_end);
      tx_idle_pct  = (ph < 2) ? 7 : (ph < 4) ? 63 : 0;
      rx_stall_pct = (ph < 2) ? 63 : (ph < 4) ? 7 : 0;
      quota = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < quota) send_random_unit();
    end
    wait_quiet();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("** delimited_frame_receiver_top: PASSED **");
    end else begin
      $display("** delimited_frame_receiver_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** delimited_frame_receiver_top: FAILED **");
    $finish;
  end

endmodule
